// File: rtl/nvp_pkg.sv
package nvp_pkg;

  localparam int LEN_W = 31;

  localparam logic [1:0] PH_NLEN  = 2'd0;
  localparam logic [1:0] PH_VLEN  = 2'd1;
  localparam logic [1:0] PH_NAME  = 2'd2;
  localparam logic [1:0] PH_VALUE = 2'd3;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_NAME   = 2'd1;
  localparam logic [1:0] KIND_VALUE  = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Extension bytes that follow the first byte of a four-byte length.
  localparam logic [1:0] LEN_EXT_BYTES = 2'd3;

  typedef struct packed {
    logic [1:0]       phase;
    logic [1:0]       lbc;
    logic [LEN_W-1:0] nlr;
    logic [LEN_W-1:0] vlr;
    logic [LEN_W-1:0] rem;
  } state_t;

  typedef struct packed {
    logic             emit;
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] nl;
    logic [LEN_W-1:0] vl;
    logic             pend;
    logic             err;
    logic             last;
  } result_t;

endpackage

// File: rtl/nvp_step.sv
module nvp_step (
  input  nvp_pkg::state_t  st,
  input  logic [7:0]       in_byte,
  input  logic             buffer_last,
  output nvp_pkg::state_t  st_next,
  output nvp_pkg::result_t res
);

  logic                      len_done;
  logic [nvp_pkg::LEN_W-1:0] len_val;
  logic [nvp_pkg::LEN_W-1:0] len_cur;
  logic [1:0]                lbc_new;
  logic [nvp_pkg::LEN_W-1:0] rem_dec;

  // Shared length assembly for whichever length is being read.
  always_comb begin
    len_cur = (st.phase == nvp_pkg::PH_NLEN) ? st.nlr : st.vlr;
    if (st.lbc == 2'd0) begin
      if (!in_byte[7]) begin
        len_val  = {{(nvp_pkg::LEN_W-8){1'b0}}, in_byte};
        lbc_new  = 2'd0;
        len_done = 1'b1;
      end else begin
        len_val  = {{(nvp_pkg::LEN_W-7){1'b0}}, in_byte[6:0]};
        lbc_new  = nvp_pkg::LEN_EXT_BYTES;
        len_done = 1'b0;
      end
    end else begin
      len_val  = {len_cur[nvp_pkg::LEN_W-9:0], in_byte};
      lbc_new  = st.lbc - 2'd1;
      len_done = (st.lbc == 2'd1);
    end
  end

  assign rem_dec = st.rem - {{(nvp_pkg::LEN_W-1){1'b0}}, 1'b1};

  always_comb begin
    st_next  = st;
    res.emit = 1'b0;
    res.kind = nvp_pkg::KIND_ERROR;
    res.data = 8'd0;
    res.nl   = '0;
    res.vl   = '0;
    res.pend = 1'b0;
    res.err  = 1'b0;
    res.last = buffer_last;

    case (st.phase)
      nvp_pkg::PH_NLEN: begin
        st_next.nlr = len_val;
        st_next.lbc = lbc_new;
        if (len_done) begin
          st_next.phase = nvp_pkg::PH_VLEN;
        end
      end
      nvp_pkg::PH_VLEN: begin
        st_next.vlr = len_val;
        st_next.lbc = lbc_new;
        if (len_done) begin
          res.emit = 1'b1;
          res.kind = nvp_pkg::KIND_HEADER;
          res.nl   = st.nlr;
          res.vl   = len_val;
          if (st.nlr != '0) begin
            st_next.phase = nvp_pkg::PH_NAME;
            st_next.rem   = st.nlr;
          end else if (len_val != '0) begin
            st_next.phase = nvp_pkg::PH_VALUE;
            st_next.rem   = len_val;
          end else begin
            st_next.phase = nvp_pkg::PH_NLEN;
            st_next.rem   = '0;
            res.pend      = 1'b1;
          end
        end
      end
      nvp_pkg::PH_NAME: begin
        res.emit    = 1'b1;
        res.kind    = nvp_pkg::KIND_NAME;
        res.data    = in_byte;
        st_next.rem = rem_dec;
        if (rem_dec == '0) begin
          if (st.vlr != '0) begin
            st_next.phase = nvp_pkg::PH_VALUE;
            st_next.rem   = st.vlr;
          end else begin
            st_next.phase = nvp_pkg::PH_NLEN;
            res.pend      = 1'b1;
          end
        end
      end
      default: begin
        res.emit    = 1'b1;
        res.kind    = nvp_pkg::KIND_VALUE;
        res.data    = in_byte;
        st_next.rem = rem_dec;
        if (rem_dec == '0) begin
          st_next.phase = nvp_pkg::PH_NLEN;
          res.pend      = 1'b1;
        end
      end
    endcase

    // The final word of a buffer always yields a result; a cut pair is flagged.
    if (buffer_last) begin
      if (!(st_next.phase == nvp_pkg::PH_NLEN && st_next.lbc == 2'd0)) begin
        res.err       = 1'b1;
        st_next.phase = nvp_pkg::PH_NLEN;
        st_next.lbc   = 2'd0;
        st_next.rem   = '0;
      end
      res.emit = 1'b1;
    end
  end

endmodule

// File: rtl/name_value_pair_decoder.sv
// The accepting edge loads the input register; the result register is loaded when
// the word advances, which a stalled output can hold off. Throughput: one word per
// cycle while the output does not stall; the pair state is updated once per word.
// Length words yield no result unless they end a value length or the buffer.
// Reset (rst, synchronous, active high) empties both registers and returns the
// decoder to expecting a name length.
module name_value_pair_decoder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_byte,
  input  logic                      buffer_last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                kind,
  output logic [7:0]                data_byte,
  output logic [nvp_pkg::LEN_W-1:0] name_length,
  output logic [nvp_pkg::LEN_W-1:0] value_length,
  output logic                      pair_end,
  output logic                      short_error,
  output logic                      buffer_end
);

  logic             in_q_valid;
  logic [7:0]       in_q_byte;
  logic             in_q_last;
  logic             advance;
  nvp_pkg::state_t  st;
  nvp_pkg::state_t  st_next;
  nvp_pkg::result_t res;

  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_byte <= in_byte;
      in_q_last <= buffer_last;
    end
  end

  nvp_step u_step (
    .st          (st),
    .in_byte     (in_q_byte),
    .buffer_last (in_q_last),
    .st_next     (st_next),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= advance && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind         <= res.kind;
      data_byte    <= res.data;
      name_length  <= res.nl;
      value_length <= res.vl;
      pair_end     <= res.pend;
      short_error  <= res.err;
      buffer_end   <= res.last;
    end
  end

`ifndef NO_ASSERTIONS
  // After the last word of a buffer the decoder always waits for a name length.
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    advance && in_q_last |=> st.phase == nvp_pkg::PH_NLEN && st.lbc == 2'd0)
    else $error("state not cleared after buffer end");

  // An error-only result is only made for a cut pair at the buffer end.
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == nvp_pkg::KIND_ERROR |-> short_error && buffer_end)
    else $error("error-only result without short buffer end");

  // Extension bytes are owed only while a length is being read.
  a_lbc_phase: assert property (@(posedge clk) disable iff (rst)
    st.lbc != 2'd0 |-> st.phase == nvp_pkg::PH_NLEN || st.phase == nvp_pkg::PH_VLEN)
    else $error("length byte count outside length phase");

  // A name or value phase always has bytes left to take.
  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    st.phase == nvp_pkg::PH_NAME || st.phase == nvp_pkg::PH_VALUE |-> st.rem != '0)
    else $error("byte phase with nothing remaining");

  // A word with no result must not disturb a waiting result.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte))
    else $error("stalled result changed");
`endif

endmodule

// File: bench/tb_name_value_pair_decoder.sv
`timescale 1ns / 1ps

module tb_name_value_pair_decoder;

  localparam int LEN_W = nvp_pkg::LEN_W;
  localparam int DIRECTED_WORDS = 25;
  localparam int RANDOM_WORDS = 550;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 150;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
  } stream_word_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_byte = 8'd0;
  logic             buffer_last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       kind;
  logic [7:0]       data_byte;
  logic [LEN_W-1:0] name_length;
  logic [LEN_W-1:0] value_length;
  logic             pair_end;
  logic             short_error;
  logic             buffer_end;

  name_value_pair_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .buffer_last  (buffer_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .data_byte    (data_byte),
    .name_length  (name_length),
    .value_length (value_length),
    .pair_end     (pair_end),
    .short_error  (short_error),
    .buffer_end   (buffer_end)
  );

  always #5 clk = ~clk;

  // Words waiting to be sent, the buffer under construction, and decoded results owed.
  stream_word_t      byte_queue[$];
  logic [7:0]        frame_bytes[$];
  nvp_pkg::result_t  decoded_queue[$];

  // Shadow of the decoder's pair state.
  logic [1:0]       dec_phase = nvp_pkg::PH_NLEN;
  logic [1:0]       ext_owed = 2'd0;
  logic [LEN_W-1:0] nlen_acc = '0;
  logic [LEN_W-1:0] vlen_acc = '0;
  logic [LEN_W-1:0] left = '0;

  int n_pushed = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_headers = 0;
  int n_pair_ends = 0;
  int n_short = 0;
  int n_input_stalls = 0;
  int mismatches = 0;
  int cycles = 0;
  int tx_gap = 0;
  int rx_wait = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  task automatic note_failure(input string msg);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string field, input logic [LEN_W-1:0] got,
                             input logic [LEN_W-1:0] want);
    if (got !== want) note_failure($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
  endtask

  function automatic int draw_wait(input bit quiet);
    if (quiet || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  // One length byte into an accumulator; done is set once the length is complete.
  task automatic absorb_length(inout logic [LEN_W-1:0] acc, input logic [7:0] b,
                               output bit done);
    done = 1'b0;
    if (ext_owed == 2'd0) begin
      if (!b[7]) begin
        acc = {23'd0, b};
        done = 1'b1;
      end else begin
        acc = {24'd0, b[6:0]};
        ext_owed = nvp_pkg::LEN_EXT_BYTES;
      end
    end else begin
      acc = {acc[LEN_W-9:0], b};
      ext_owed = ext_owed - 2'd1;
      done = (ext_owed == 2'd0);
    end
  endtask

  // Leaves the name part; returns 1 when an empty value closes the pair.
  function automatic bit skip_to_value();
    if (vlen_acc == '0) begin
      dec_phase = nvp_pkg::PH_NLEN;
      left = '0;
      return 1'b1;
    end
    dec_phase = nvp_pkg::PH_VALUE;
    left = vlen_acc;
    return 1'b0;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic last);
    nvp_pkg::result_t res;
    bit done;
    res = '0;
    res.kind = nvp_pkg::KIND_ERROR;
    res.last = last;
    case (dec_phase)
      nvp_pkg::PH_NLEN: begin
        absorb_length(nlen_acc, b, done);
        if (done) dec_phase = nvp_pkg::PH_VLEN;
      end
      nvp_pkg::PH_VLEN: begin
        absorb_length(vlen_acc, b, done);
        if (done) begin
          res.emit = 1'b1;
          res.kind = nvp_pkg::KIND_HEADER;
          res.nl = nlen_acc;
          res.vl = vlen_acc;
          if (nlen_acc == '0) begin
            res.pend = skip_to_value();
          end else begin
            dec_phase = nvp_pkg::PH_NAME;
            left = nlen_acc;
          end
        end
      end
      nvp_pkg::PH_NAME: begin
        res.emit = 1'b1;
        res.kind = nvp_pkg::KIND_NAME;
        res.data = b;
        left = left - LEN_W'(1);
        if (left == '0) res.pend = skip_to_value();
      end
      default: begin
        res.emit = 1'b1;
        res.kind = nvp_pkg::KIND_VALUE;
        res.data = b;
        left = left - LEN_W'(1);
        if (left == '0) begin
          dec_phase = nvp_pkg::PH_NLEN;
          res.pend = 1'b1;
        end
      end
    endcase
    // The last word of a buffer always yields a result and resynchronizes the decoder.
    if (last) begin
      if (!(dec_phase == nvp_pkg::PH_NLEN && ext_owed == 2'd0)) begin
        res.err = 1'b1;
        dec_phase = nvp_pkg::PH_NLEN;
        ext_owed = 2'd0;
        left = '0;
      end
      res.emit = 1'b1;
    end
    if (res.emit) begin
      decoded_queue.push_back(res);
      if (res.kind == nvp_pkg::KIND_HEADER) n_headers++;
      if (res.pend) n_pair_ends++;
      if (res.err) n_short++;
    end
  endtask

  task automatic push_word(input logic [7:0] b, input logic last);
    stream_word_t w;
    w.octet = b;
    w.last = last;
    byte_queue.push_back(w);
    n_pushed++;
  endtask

  task automatic add_length(input logic [LEN_W-1:0] len, input bit wide);
    if (wide) begin
      frame_bytes.push_back({1'b1, len[30:24]});
      frame_bytes.push_back(len[23:16]);
      frame_bytes.push_back(len[15:8]);
      frame_bytes.push_back(len[7:0]);
    end else begin
      frame_bytes.push_back({1'b0, len[6:0]});
    end
  endtask

  task automatic add_pair(input int nlen, input int vlen, input bit wide_n, input bit wide_v);
    add_length(LEN_W'(nlen), wide_n);
    add_length(LEN_W'(vlen), wide_v);
    repeat (nlen + vlen) frame_bytes.push_back(8'($urandom()));
  endtask

  // Sends the first keep bytes of the frame, flagging the last one sent.
  task automatic flush_frame(input int keep);
    int n;
    n = (keep < frame_bytes.size()) ? keep : frame_bytes.size();
    for (int i = 0; i < n; i++) push_word(frame_bytes[i], i == n - 1);
    frame_bytes.delete();
  endtask

  function automatic int pick_length();
    if ($urandom_range(0, 4) == 0) return 0;
    return $urandom_range(1, 10);
  endfunction

  initial begin
    int npairs;
    int mode;

    // Both lengths empty: the header closes the pair and ends the buffer cleanly.
    add_pair(0, 0, 1'b0, 1'b0);
    flush_frame(1000);
    // Name only.
    add_pair(1, 0, 1'b0, 1'b0);
    flush_frame(1000);
    // Four-byte encodings of zero and two.
    add_pair(0, 2, 1'b1, 1'b1);
    flush_frame(1000);
    // Buffer ends inside a four-byte length.
    frame_bytes.push_back(8'h85);
    flush_frame(1000);
    // Largest four-byte name length and largest one-byte value length, cut at the header.
    add_length(31'h7fffffff, 1'b1);
    add_length(31'd127, 1'b0);
    flush_frame(1000);
    // Buffer ends inside the value bytes.
    add_pair(1, 3, 1'b0, 1'b0);
    flush_frame(4);

    while (n_pushed < DIRECTED_WORDS + RANDOM_WORDS) begin
      mode = $urandom_range(0, 9);
      if (mode <= 6) begin
        npairs = $urandom_range(1, 4);
        repeat (npairs) begin
          add_pair(pick_length(), pick_length(), $urandom_range(0, 3) == 0,
                   $urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 4) == 0) flush_frame($urandom_range(1, frame_bytes.size()));
        else flush_frame(frame_bytes.size());
      end else if (mode == 7) begin
        // Huge lengths that the buffer cannot hold.
        add_length(31'($urandom()), 1'b1);
        if ($urandom_range(0, 1) == 0) add_length(31'($urandom()), 1'b1);
        else add_length(31'($urandom_range(0, 127)), 1'b0);
        repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom()));
        flush_frame($urandom_range(1, frame_bytes.size()));
      end else begin
        npairs = $urandom_range(1, 8);
        for (int i = 0; i < npairs; i++) begin
          push_word(8'($urandom()), (i == npairs - 1) || ($urandom_range(0, 5) == 0));
        end
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_pushed) @(posedge clk);
    while (decoded_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (decoded_queue.size() != 0) note_failure("results still expected at the end");
    $display("%0d words in, %0d results checked: %0d headers, %0d completed pairs, %0d short buffers",
             n_accepted, n_results, n_headers, n_pair_ends, n_short);
    $display("input stalled on %0d cycles, output held off once for %0d cycles",
             n_input_stalls, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("tb_name_value_pair_decoder OK");
    end else begin
      $display("tb_name_value_pair_decoder NOT OK");
    end
    $finish;
  end

  // Driver: presents the next word after its idle gap, holding it while stalled.
  always @(posedge clk) begin
    stream_word_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_byte, buffer_last);
        n_accepted <= n_accepted + 1;
      end
      if (in_valid && in_stall) n_input_stalls <= n_input_stalls + 1;
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          in_valid <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (byte_queue.size() != 0) begin
          nxt = byte_queue.pop_front();
          in_valid <= 1'b1;
          in_byte <= nxt.octet;
          buffer_last <= nxt.last;
          tx_gap <= draw_wait(tx_quiet);
          if ($urandom_range(0, 40) == 0) tx_quiet <= !tx_quiet;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // One long output hold-off so that the decoder fills and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    nvp_pkg::result_t want;
    int w;
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
    end else begin
      w = (rx_wait > 0) ? rx_wait - 1 : 0;
      if (out_valid && !out_stall) begin
        if (decoded_queue.size() == 0) begin
          note_failure("result arrived with none expected");
        end else begin
          want = decoded_queue.pop_front();
          check_field("kind", LEN_W'(kind), LEN_W'(want.kind));
          check_field("data_byte", LEN_W'(data_byte), LEN_W'(want.data));
          check_field("name_length", name_length, want.nl);
          check_field("value_length", value_length, want.vl);
          check_field("pair_end", LEN_W'(pair_end), LEN_W'(want.pend));
          check_field("short_error", LEN_W'(short_error), LEN_W'(want.err));
          check_field("buffer_end", LEN_W'(buffer_end), LEN_W'(want.last));
        end
        n_results <= n_results + 1;
        w = draw_wait(rx_quiet);
        if ($urandom_range(0, 40) == 0) rx_quiet <= !rx_quiet;
      end
      rx_wait <= w;
      out_stall <= (w > 0) || (hold_left > 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_name_value_pair_decoder NOT OK");
      $finish;
    end
  end

endmodule

// File: filelist.f
rtl/nvp_pkg.sv
rtl/nvp_step.sv
rtl/name_value_pair_decoder.sv
bench/tb_name_value_pair_decoder.sv
